@@ src/lco_pkg.sv @@
// shared types and constants for the line clip outcode unit
`timescale 1ns / 1ps

package lco_pkg;

  // outcode bits
  localparam logic [3:0] CODE_LEFT   = 4'h1;
  localparam logic [3:0] CODE_RIGHT  = 4'h2;
  localparam logic [3:0] CODE_BOTTOM = 4'h4;
  localparam logic [3:0] CODE_TOP    = 4'h8;

  // clip passes before a segment is given up
  localparam int unsigned PASS_W     = 4;
  localparam logic [PASS_W-1:0] MAX_PASSES = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CALC,
    ST_UPDATE,
    ST_OUT
  } clip_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  // control towards the serial multiply-divide unit
  typedef struct packed {
    logic start;
  } md_ctrl_t;

  // status back from the serial multiply-divide unit
  typedef struct packed {
    logic done;
  } md_stat_t;

endpackage

@@ src/lco_muldiv.sv @@
// bit-serial unsigned multiply then restoring divide: quot = ma * mb / mc
`timescale 1ns / 1ps

module lco_muldiv #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lco_pkg::md_ctrl_t      ctrl_i,
  input  logic [COORD_WIDTH-1:0] ma_i,
  input  logic [COORD_WIDTH-1:0] mb_i,
  input  logic [COORD_WIDTH-1:0] mc_i,
  output lco_pkg::md_stat_t      stat_o,
  output logic [COORD_WIDTH-1:0] quot_o
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned CNT_W = $clog2(COORD_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_WIDTH - 1);

  lco_pkg::md_state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [W-1:0]       ma_q, ma_d;
  logic [W-1:0]       mb_q, mb_d;
  logic [W-1:0]       mc_q, mc_d;
  logic [2*W-1:0]     acc_q, acc_d;

  logic [W:0]         trial;
  logic [W:0]         trial_sub;
  logic               ge;

  // one restoring division step on the top half
  assign trial     = {acc_q[2*W-1:W], acc_q[W-1]};
  assign trial_sub = trial - {1'b0, mc_q};
  assign ge        = (trial >= {1'b0, mc_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ma_d    = ma_q;
    mb_d    = mb_q;
    mc_d    = mc_q;
    acc_d   = acc_q;
    unique case (state_q)
      lco_pkg::MD_IDLE: begin
        if (ctrl_i.start) begin
          ma_d    = ma_i;
          mb_d    = mb_i;
          mc_d    = mc_i;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = lco_pkg::MD_MUL;
        end
      end
      lco_pkg::MD_MUL: begin
        // shift-add, multiplier bits msb first
        acc_d = {acc_q[2*W-2:0], 1'b0} + (ma_q[W-1] ? {{W{1'b0}}, mb_q} : '0);
        ma_d  = {ma_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = lco_pkg::MD_DIV;
        end
      end
      lco_pkg::MD_DIV: begin
        acc_d = {(ge ? trial_sub[W-1:0] : trial[W-1:0]), acc_q[W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          done_d  = 1'b1;
          state_d = lco_pkg::MD_IDLE;
        end
      end
      default: state_d = lco_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lco_pkg::MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    mc_q  <= mc_d;
    acc_q <= acc_d;
  end

  assign stat_o.done = done_q;
  assign quot_o      = acc_q[W-1:0];

endmodule

@@ src/line_clip_outcode_unit.sv @@
// top level of the line clip outcode unit
`timescale 1ns / 1ps

// Clips one segment per transfer against the window in the four config
// registers (cohen-sutherland). Each clip pass forms the outcodes, waits on
// the serial multiply-divide unit for the intersection (multiply, divide and
// its done flag) and then moves the endpoint; a segment needs up to
// MAX_PASSES passes and none if it is trivially accepted or rejected, and a
// finished segment waits for the result register to free up. One segment is
// in work at a time; the result register lets the next segment be taken
// while the previous result still waits on the master side. Rejected
// segments give tuser 0 and all-zero coordinates.
module line_clip_outcode_unit #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  // segment in
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // fields from bit 0: x_a, y_a, x_b, y_b, zero padding
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // clipped segment out
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // fields from bit 0: clip_x_a, clip_y_a, clip_x_b, clip_y_b, zero padding
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // fields from bit 0: accepted
  output logic                   m_axis_tuser_o
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned DATA_W = ((4*COORD_WIDTH+7)/8)*8;
  localparam int unsigned PAD_W  = DATA_W - 4*COORD_WIDTH;

  // window registers
  logic signed [W-1:0] x_min_q, y_min_q, x_max_q, y_max_q;

  // working endpoints
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [W-1:0] x1_d, y1_d, x2_d, y2_d;
  logic [lco_pkg::PASS_W-1:0] pass_q, pass_d;

  // per-pass context held while the divide runs
  logic                move_a_q, move_a_d;
  logic                is_x_q, is_x_d;
  logic signed [W-1:0] edge_q, edge_d;
  logic signed [W-1:0] other_q, other_d;
  logic                neg_q, neg_d;
  logic                acc_q, acc_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic                out_acc_q, out_acc_d;
  logic [4*W-1:0]      out_data_q, out_data_d;

  lco_pkg::clip_state_e state_q, state_d;

  // outcode evaluation
  logic [3:0]          c1, c2, code;
  logic                dec_acc, dec_rej;
  logic                move_a, is_x;
  logic signed [W-1:0] px, py, ox, oy;
  logic signed [W-1:0] p_along, p_other, o_along, o_other, edge_val;
  logic signed [W:0]   diff_a, diff_b, diff_c;
  logic [W:0]          abs_a, abs_b, abs_c;

  // endpoint update
  logic signed [W:0]   offset;
  logic signed [W:0]   moved;
  logic [W-1:0]        quot;
  logic                out_free;

  lco_pkg::md_ctrl_t   md_ctrl;
  lco_pkg::md_stat_t   md_stat;

  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] xmin,
    input logic signed [W-1:0] ymin,
    input logic signed [W-1:0] xmax,
    input logic signed [W-1:0] ymax
  );
    logic [3:0] c;
    c = '0;
    if (x < xmin) c = c | lco_pkg::CODE_LEFT;
    if (x > xmax) c = c | lco_pkg::CODE_RIGHT;
    if (y < ymin) c = c | lco_pkg::CODE_BOTTOM;
    if (y > ymax) c = c | lco_pkg::CODE_TOP;
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= '0;
      y_min_q <= '0;
      x_max_q <= W'(1023);
      y_max_q <= W'(1023);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lco_pkg::REG_X_MIN: x_min_q <= cfg_data_i;
        lco_pkg::REG_Y_MIN: y_min_q <= cfg_data_i;
        lco_pkg::REG_X_MAX: x_max_q <= cfg_data_i;
        lco_pkg::REG_Y_MAX: y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    c1      = outcode(x1_q, y1_q, x_min_q, y_min_q, x_max_q, y_max_q);
    c2      = outcode(x2_q, y2_q, x_min_q, y_min_q, x_max_q, y_max_q);
    dec_acc = ((c1 | c2) == 4'h0);
    dec_rej = ((c1 & c2) != 4'h0) || (pass_q == lco_pkg::MAX_PASSES);
    move_a  = (c1 != 4'h0);
    code    = move_a ? c1 : c2;
    px      = move_a ? x1_q : x2_q;
    py      = move_a ? y1_q : y2_q;
    ox      = move_a ? x2_q : x1_q;
    oy      = move_a ? y2_q : y1_q;
    // edge in priority order left, right, bottom, top
    is_x    = ((code & (lco_pkg::CODE_LEFT | lco_pkg::CODE_RIGHT)) != 4'h0);
    if ((code & lco_pkg::CODE_LEFT) != 4'h0)        edge_val = x_min_q;
    else if ((code & lco_pkg::CODE_RIGHT) != 4'h0)  edge_val = x_max_q;
    else if ((code & lco_pkg::CODE_BOTTOM) != 4'h0) edge_val = y_min_q;
    else                                             edge_val = y_max_q;
    p_along = is_x ? px : py;
    p_other = is_x ? py : px;
    o_along = is_x ? ox : oy;
    o_other = is_x ? oy : ox;
    diff_a  = {edge_val[W-1], edge_val} - {p_along[W-1], p_along};
    diff_b  = {o_other[W-1], o_other} - {p_other[W-1], p_other};
    diff_c  = {o_along[W-1], o_along} - {p_along[W-1], p_along};
    abs_a   = diff_a[W] ? -diff_a : diff_a;
    abs_b   = diff_b[W] ? -diff_b : diff_b;
    abs_c   = diff_c[W] ? -diff_c : diff_c;
  end

  assign md_ctrl.start = (state_q == lco_pkg::ST_EVAL) && !dec_acc && !dec_rej;

  lco_muldiv #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(md_ctrl),
    .ma_i  (abs_a[W-1:0]),
    .mb_i  (abs_b[W-1:0]),
    .mc_i  (abs_c[W-1:0]),
    .stat_o(md_stat),
    .quot_o(quot)
  );

  // signed offset added to the other coordinate
  assign offset   = neg_q ? -{1'b0, quot} : {1'b0, quot};
  assign moved    = {other_q[W-1], other_q} + offset;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lco_pkg::ST_IDLE:   if (s_axis_tvalid_i) state_d = lco_pkg::ST_EVAL;
      lco_pkg::ST_EVAL:   state_d = (dec_acc || dec_rej) ? lco_pkg::ST_OUT
                                                         : lco_pkg::ST_CALC;
      lco_pkg::ST_CALC:   if (md_stat.done) state_d = lco_pkg::ST_UPDATE;
      lco_pkg::ST_UPDATE: state_d = lco_pkg::ST_EVAL;
      lco_pkg::ST_OUT:    if (out_free) state_d = lco_pkg::ST_IDLE;
      default:            state_d = lco_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    x1_d        = x1_q;
    y1_d        = y1_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    pass_d      = pass_q;
    move_a_d    = move_a_q;
    is_x_d      = is_x_q;
    edge_d      = edge_q;
    other_d     = other_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_acc_d   = out_acc_q;
    out_data_d  = out_data_q;
    unique case (state_q)
      lco_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          x1_d   = s_axis_tdata_i[W-1:0];
          y1_d   = s_axis_tdata_i[2*W-1:W];
          x2_d   = s_axis_tdata_i[3*W-1:2*W];
          y2_d   = s_axis_tdata_i[4*W-1:3*W];
          pass_d = '0;
        end
      end
      lco_pkg::ST_EVAL: begin
        acc_d    = dec_acc;
        move_a_d = move_a;
        is_x_d   = is_x;
        edge_d   = edge_val;
        other_d  = p_other;
        neg_d    = diff_a[W] ^ diff_b[W] ^ diff_c[W];
      end
      lco_pkg::ST_CALC: ;
      lco_pkg::ST_UPDATE: begin
        pass_d = pass_q + 1'b1;
        if (move_a_q) begin
          x1_d = is_x_q ? edge_q : moved[W-1:0];
          y1_d = is_x_q ? moved[W-1:0] : edge_q;
        end else begin
          x2_d = is_x_q ? edge_q : moved[W-1:0];
          y2_d = is_x_q ? moved[W-1:0] : edge_q;
        end
      end
      lco_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_data_d  = acc_q ? {y2_q, x2_q, y1_q, x1_q} : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lco_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q       <= x1_d;
    y1_q       <= y1_d;
    x2_q       <= x2_d;
    y2_q       <= y2_d;
    move_a_q   <= move_a_d;
    is_x_q     <= is_x_d;
    edge_q     <= edge_d;
    other_q    <= other_d;
    neg_q      <= neg_d;
    acc_q      <= acc_d;
    out_acc_q  <= out_acc_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == lco_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_acc_q;

  generate
    if (PAD_W > 0) begin : g_pad
      assign m_axis_tdata_o = {{PAD_W{1'b0}}, out_data_q};
    end else begin : g_nopad
      assign m_axis_tdata_o = out_data_q;
    end
  endgenerate

endmodule

@@ tb/tb_line_clip_outcode_unit.sv @@
// self-checking testbench for the line clip outcode unit
`timescale 1ns / 1ps

module tb_line_clip_outcode_unit;

  localparam int unsigned CW = 16;
  localparam int unsigned DW = ((4*CW+7)/8)*8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic   accepted;
    coord_t cx_a;
    coord_t cy_a;
    coord_t cx_b;
    coord_t cy_b;
  } clip_res_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = lco_pkg::REG_X_MIN;
  logic [CW-1:0] cfg_data_i = '0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  // x_a, y_a, x_b, y_b from bit 0
  logic [DW-1:0] s_axis_tdata_i = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  // clip_x_a, clip_y_a, clip_x_b, clip_y_b from bit 0
  logic [DW-1:0] m_axis_tdata_o;
  // accepted
  logic          m_axis_tuser_o;

  line_clip_outcode_unit #(.COORD_WIDTH(CW)) uut (.*);

  // window copy held by the predictor
  longint wx_min = 0, wy_min = 0, wx_max = 1023, wy_max = 1023;

  clip_res_t clip_queue[$];
  int        n_errors = 0;
  bit        rx_free = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // generous time bound for all 665 items plus stalls
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < wx_min) c |= lco_pkg::CODE_LEFT;
    if (x > wx_max) c |= lco_pkg::CODE_RIGHT;
    if (y < wy_min) c |= lco_pkg::CODE_BOTTOM;
    if (y > wy_max) c |= lco_pkg::CODE_TOP;
    return c;
  endfunction

  // exact trunc(a*b/c), offset clamped to the span
  function automatic longint edge_offset(longint a, longint b, longint c);
    longint ma, q;
    if (c == 0) return 0;
    ma = (a < 0) ? -a : a;
    if (ma > ((c < 0) ? -c : c)) ma = (c < 0) ? -c : c;
    if (a < 0) ma = -ma;
    q = (ma * b) / c;   // sv division truncates toward zero
    return q;
  endfunction

  function automatic clip_res_t clip_segment(coord_t xa, coord_t ya, coord_t xb, coord_t yb);
    longint x1, y1, x2, y2, px, py, ox, oy;
    logic [3:0] c1, c2, c;
    bit ok, mov_a;
    clip_res_t r;
    x1 = xa; y1 = ya; x2 = xb; y2 = yb;
    ok = 1'b0;
    for (int pass = 0; pass <= lco_pkg::MAX_PASSES; pass++) begin
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      if ((c1 | c2) == 0) begin
        ok = 1'b1;
        break;
      end
      if ((c1 & c2) != 0 || pass == lco_pkg::MAX_PASSES) break;
      mov_a = (c1 != 0);
      c  = mov_a ? c1 : c2;
      px = mov_a ? x1 : x2;  py = mov_a ? y1 : y2;
      ox = mov_a ? x2 : x1;  oy = mov_a ? y2 : y1;
      if (c & lco_pkg::CODE_LEFT) begin
        py += edge_offset(wx_min - px, oy - py, ox - px);  px = wx_min;
      end else if (c & lco_pkg::CODE_RIGHT) begin
        py += edge_offset(wx_max - px, oy - py, ox - px);  px = wx_max;
      end else if (c & lco_pkg::CODE_BOTTOM) begin
        px += edge_offset(wy_min - py, ox - px, oy - py);  py = wy_min;
      end else begin
        px += edge_offset(wy_max - py, ox - px, oy - py);  py = wy_max;
      end
      if (mov_a) begin
        x1 = px; y1 = py;
      end else begin
        x2 = px; y2 = py;
      end
    end
    r = '0;
    if (ok) begin
      r.accepted = 1'b1;
      r.cx_a = coord_t'(x1); r.cy_a = coord_t'(y1);
      r.cx_b = coord_t'(x2); r.cy_b = coord_t'(y2);
    end
    return r;
  endfunction

  // receiver: random stall pattern, checks each transfer against the oldest entry
  initial begin
    clip_res_t exp_r;
    int mode;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (clip_queue.size() == 0) begin
          $error("unexpected result transfer");
          n_errors++;
        end else begin
          exp_r = clip_queue.pop_front();
          if (m_axis_tuser_o !== exp_r.accepted) begin
            $error("accepted exp %0d got %0d", exp_r.accepted, m_axis_tuser_o); n_errors++;
          end
          if ($signed(m_axis_tdata_o[CW-1:0]) !== exp_r.cx_a) begin
            $error("clip_x_a exp %0d got %0d", exp_r.cx_a, $signed(m_axis_tdata_o[CW-1:0]));
            n_errors++;
          end
          if ($signed(m_axis_tdata_o[2*CW-1:CW]) !== exp_r.cy_a) begin
            $error("clip_y_a exp %0d got %0d", exp_r.cy_a, $signed(m_axis_tdata_o[2*CW-1:CW]));
            n_errors++;
          end
          if ($signed(m_axis_tdata_o[3*CW-1:2*CW]) !== exp_r.cx_b) begin
            $error("clip_x_b exp %0d got %0d", exp_r.cx_b,
                   $signed(m_axis_tdata_o[3*CW-1:2*CW]));
            n_errors++;
          end
          if ($signed(m_axis_tdata_o[4*CW-1:3*CW]) !== exp_r.cy_b) begin
            $error("clip_y_b exp %0d got %0d", exp_r.cy_b,
                   $signed(m_axis_tdata_o[4*CW-1:3*CW]));
            n_errors++;
          end
        end
      end
      // stretches of free flow and of random stalls
      mode = ($urandom_range(0, 99) < 3) ? $urandom_range(0, 2) : -1;
      if (mode == 0) rx_free = 1'b1;
      if (mode == 1) rx_free = 1'b0;
      m_axis_tready_i <= rx_free ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  int burst_left = 0;

  // sends one segment and queues its predicted result; valid stays up inside a burst
  task automatic send_segment(coord_t xa, coord_t ya, coord_t xb, coord_t yb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 200);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DW'({yb, xb, ya, xa});
    clip_queue.push_back(clip_segment(xa, ya, xb, yb));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // waits until every result transfer is in, plus the block latency
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (clip_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_window(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    drain();
    @(posedge clk_i); cfg_we_i <= 1'b1; cfg_idx_i <= lco_pkg::REG_X_MIN; cfg_data_i <= x0;
    @(posedge clk_i); cfg_idx_i <= lco_pkg::REG_Y_MIN; cfg_data_i <= y0;
    @(posedge clk_i); cfg_idx_i <= lco_pkg::REG_X_MAX; cfg_data_i <= x1;
    @(posedge clk_i); cfg_idx_i <= lco_pkg::REG_Y_MAX; cfg_data_i <= y1;
    @(posedge clk_i); cfg_we_i <= 1'b0;
    wx_min = x0; wy_min = y0; wx_max = x1; wy_max = y1;
  endtask

  function automatic coord_t rand_coord(longint lo, longint hi);
    longint v;
    v = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return coord_t'(v);
  endfunction

  // trivial cases, each edge, vertical and horizontal lines, extremes
  task automatic test_directed();
    send_segment(100, 100, 900, 900);
    send_segment(-50, -50, -10, 500);
    send_segment(-100, 500, 500, 500);
    send_segment(500, -100, 500, 2000);
    send_segment(2000, 100, 100, 2000);
    send_segment(-500, 1500, 1500, -500);
    send_segment(500, 500, 2000, 600);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(0, 0, 1023, 1023);
    send_segment(-1, 0, 1024, 1023);
    send_segment(-32768, 32767, -32768, -32768);
    send_segment(1200, 1200, 1300, 1300);
  endtask

  // inverted window: everything rejected
  task automatic test_inverted_window();
    set_window(500, 500, 100, 100);
    send_segment(300, 300, 300, 300);
    send_segment(-1000, -1000, 1000, 1000);
  endtask

  // mostly segments crossing the window, some far noise, at a given window
  task automatic test_random(int count, coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    longint lx, ly, hx, hy;
    coord_t c[4];
    set_window(x0, y0, x1, y1);
    lx = x0; ly = y0; hx = x1; hy = y1;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 9) < 2)
          c[k] = coord_t'($urandom());
        else if (k % 2 == 0)
          c[k] = rand_coord((lx - 800 < -32768) ? -32768 : lx - 800,
                            (hx + 800 > 32767) ? 32767 : hx + 800);
        else
          c[k] = rand_coord((ly - 800 < -32768) ? -32768 : ly - 800,
                            (hy + 800 > 32767) ? 32767 : hy + 800);
      end
      if ($urandom_range(0, 19) == 0) c[2] = c[0];
      if ($urandom_range(0, 19) == 0) c[3] = c[1];
      send_segment(c[0], c[1], c[2], c[3]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200, 0, 0, 1023, 1023);
    test_random(150, -400, -300, 300, 700);
    test_random(100, -32768, -32768, 32767, 32767);
    test_random(100, 32000, -32768, 32767, -32000);
    test_random(100, 5, 5, 5, 5);
    test_inverted_window();
    drain();
    if (n_errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
